// ----- src/cacp_pkg.sv -----
// Shared types and constants for the call-auction clearing block.
// No dependencies.
`timescale 1ns / 1ps
package cacp_pkg;
	localparam logic [1:0] ACT_BUY   = 2'd0;
	localparam logic [1:0] ACT_SELL  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_UNDEF = 2'd3;
	localparam int QSUM_W = 29; // 4096 * 65535 fits in 28 bits
	localparam logic [23:0] MAX24 = 24'hFFFFFF;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FALL, ST_CAND_RD, ST_CAND_LAT, ST_SCAN_B, ST_SCAN_S,
		ST_EVAL, ST_FIN_START, ST_FIN_B, ST_FIN_S, ST_DONE, ST_OUT
	} state_t;

	typedef struct packed {
		logic load_item;   // capture input item, write book if room
		logic fall_price;  // set no-buy/no-sell fallback as final price, clear sums
		logic cand_rd;     // read candidate entry
		logic cand_lat;    // latch candidate price, clear sums
		logic scan_b;      // read/accumulate buy entry
		logic scan_s;      // read/accumulate sell entry
		logic eval;        // compare candidate with best
		logic fin_start;   // set best price as final price, clear sums
		logic done;        // build result, update last price, empty books
		logic cfg_we;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       buy_empty;
		logic       sell_empty;
		logic       cand_last;   // candidate index at last entry
		logic       scan_last_b; // scan index at last buy entry
		logic       scan_last_s; // scan index at last sell entry
		logic       acc_pending; // a read is in flight
	} stat_t;
endpackage

// ----- src/cacp_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cacp_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- src/cacp_datapath.sv -----
// Datapath: order books, counts, sums, best-candidate registers, result.
// Depends on cacp_pkg and cacp_ram.
`timescale 1ns / 1ps
module cacp_datapath import cacp_pkg::*; #(
	parameter int BOOK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [41:0] item,
	input  logic [23:0] cfg_data,
	output logic [96:0] result
);
	localparam int AW = $clog2(BOOK_DEPTH);
	localparam int CW = $clog2(BOOK_DEPTH + 1);

	logic [1:0]  act_q;
	logic [23:0] last_q, cand_q, best_p_q, res_p_q;
	logic [CW-1:0] bcnt_q, scnt_q;
	logic [CW:0]   ci_q;          // candidate index over buys then sells
	logic [AW-1:0] si_q;          // scan index
	logic          rd_b_s1, rd_s_s1, rd_c_s1;
	logic [QSUM_W-1:0] dsum_q, ssum_q, best_v_q, best_b_q;
	logic          best_ok_q, acc_q;
	logic [96:0]   result_q;
	logic [39:0]   brd, srd;
	logic [AW-1:0] braddr, sraddr;
	logic          bwe, swe;
	logic          cand_sell;
	logic [QSUM_W-1:0] vol, bal;
	logic          take;
	logic [55:0]   mul9, mul11;
	logic [24:0]   q9, q11;
	logic [23:0]   fall_p;
	logic          sum_clr;

	assign cand_sell = (ci_q >= (CW+1)'(bcnt_q));
	assign bwe = cmd.load_item && item[1:0] == ACT_BUY && bcnt_q < CW'(BOOK_DEPTH);
	assign swe = cmd.load_item && item[1:0] == ACT_SELL && scnt_q < CW'(BOOK_DEPTH);

	always_comb begin
		braddr = si_q;
		sraddr = si_q;
		if (cmd.cand_rd) begin
			braddr = ci_q[AW-1:0];
			sraddr = AW'(ci_q - (CW+1)'(bcnt_q));
		end
	end

	cacp_ram #(.WIDTH(40), .DEPTH(BOOK_DEPTH)) u_buy (
		.clk, .we(bwe), .waddr(bcnt_q[AW-1:0]), .wdata({item[25:2], item[41:26]}),
		.raddr(braddr), .rdata(brd));
	cacp_ram #(.WIDTH(40), .DEPTH(BOOK_DEPTH)) u_sell (
		.clk, .we(swe), .waddr(scnt_q[AW-1:0]), .wdata({item[25:2], item[41:26]}),
		.raddr(sraddr), .rdata(srd));

	// Scale by 9/10 and 11/10 with one reciprocal multiply each: floor(x/10) equals
	// floor(x * 214748365 >> 31) for x below 2^30, and 9*last, 11*last stay below 2^28.
	assign mul9  = 56'(last_q) * 56'd1932735285;
	assign mul11 = 56'(last_q) * 56'd2362232015;
	assign q9  = mul9[55:31];
	assign q11 = mul11[55:31];
	assign fall_p = stat.buy_empty ? q9[23:0] : (q11 > 25'(MAX24) ? MAX24 : q11[23:0]);

	assign vol  = (dsum_q < ssum_q) ? dsum_q : ssum_q;
	assign bal  = (dsum_q > ssum_q) ? dsum_q - ssum_q : ssum_q - dsum_q;
	always_comb begin
		if (!best_ok_q) take = 1'b1;
		else if (vol != best_v_q) take = vol > best_v_q;
		else if (bal != best_b_q) take = bal < best_b_q;
		else take = cand_q < best_p_q;
	end

	function automatic logic [23:0] sat(input logic [QSUM_W-1:0] v);
		return (v > QSUM_W'(MAX24)) ? MAX24 : v[23:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q <= '0; scnt_q <= '0; last_q <= 24'd5120;
			rd_b_s1 <= 1'b0; rd_s_s1 <= 1'b0; rd_c_s1 <= 1'b0; acc_q <= 1'b0;
		end else begin
			rd_b_s1 <= cmd.scan_b;
			rd_s_s1 <= cmd.scan_s;
			rd_c_s1 <= cmd.cand_rd;
			acc_q   <= cmd.scan_b || cmd.scan_s || cmd.cand_rd;
			if (cmd.done) begin
				bcnt_q <= '0; scnt_q <= '0; last_q <= res_p_q;
			end else begin
				if (cmd.cfg_we) last_q <= cfg_data;
				if (bwe) bcnt_q <= bcnt_q + 1'b1;
				if (swe) scnt_q <= scnt_q + 1'b1;
			end
		end
	end

	assign sum_clr = cmd.fall_price || cmd.fin_start || cmd.cand_lat;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			act_q <= item[1:0];
			ci_q <= '0; best_ok_q <= 1'b0;
			result_q <= {96'd0, bwe || swe};
		end else if (cmd.done) begin
			result_q <= {sat(ssum_q), sat(dsum_q), sat(vol), res_p_q, 1'b1};
		end
		if (cmd.fall_price) begin
			res_p_q <= fall_p; cand_q <= fall_p;
		end else if (cmd.fin_start) begin
			res_p_q <= best_p_q; cand_q <= best_p_q;
		end else if (cmd.cand_lat) begin
			cand_q <= cand_sell ? srd[39:16] : brd[39:16];
		end
		if (sum_clr) begin
			dsum_q <= '0; ssum_q <= '0;
		end else begin
			if (rd_b_s1 && brd[39:16] >= cand_q) dsum_q <= dsum_q + QSUM_W'(brd[15:0]);
			if (rd_s_s1 && srd[39:16] <= cand_q) ssum_q <= ssum_q + QSUM_W'(srd[15:0]);
		end
		if (sum_clr) si_q <= '0;
		else if (cmd.scan_b && stat.scan_last_b) si_q <= '0;
		else if (cmd.scan_b || cmd.scan_s) si_q <= si_q + 1'b1;
		if (cmd.eval) begin
			ci_q <= ci_q + 1'b1;
			if (take) begin
				best_ok_q <= 1'b1; best_v_q <= vol; best_b_q <= bal; best_p_q <= cand_q;
			end
		end
	end

	always_comb begin
		stat.action      = act_q;
		stat.buy_empty   = (bcnt_q == '0);
		stat.sell_empty  = (scnt_q == '0);
		stat.cand_last   = (ci_q == (CW+1)'(bcnt_q) + (CW+1)'(scnt_q) - 1'b1);
		stat.scan_last_b = (CW'(si_q) == bcnt_q - 1'b1);
		stat.scan_last_s = (CW'(si_q) == scnt_q - 1'b1);
		stat.acc_pending = acc_q || rd_c_s1;
	end
	assign result = result_q;
endmodule

// ----- src/cacp_ctrl.sv -----
// Controller state machine sequencing loads and the clearing search.
// Depends on cacp_pkg.
`timescale 1ns / 1ps
module cacp_ctrl import cacp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  out_fire,
	input  logic  cfg_fire,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  in_rdy,
	output logic  out_vld
);
	state_t st_q, st_d;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end
	always_comb begin
		st_d = st_q; cmd = '0; in_rdy = 1'b0; out_vld = 1'b0;
		cmd.cfg_we = cfg_fire;
		unique case (st_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (in_fire) begin
					cmd.load_item = 1'b1;
					st_d = ST_FALL;
				end
			end
			ST_FALL: begin
				if (stat.action != ACT_CLEAR) st_d = ST_OUT;
				else if (stat.buy_empty || stat.sell_empty) begin
					cmd.fall_price = 1'b1; st_d = ST_FIN_B;
				end else st_d = ST_CAND_RD;
			end
			ST_CAND_RD: begin cmd.cand_rd = 1'b1; st_d = ST_CAND_LAT; end
			ST_CAND_LAT: begin cmd.cand_lat = 1'b1; st_d = ST_SCAN_B; end
			ST_SCAN_B: begin
				cmd.scan_b = 1'b1;
				if (stat.scan_last_b) st_d = ST_SCAN_S;
			end
			ST_SCAN_S: begin
				cmd.scan_s = 1'b1;
				if (stat.scan_last_s) st_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!stat.acc_pending) begin
					cmd.eval = 1'b1;
					st_d = stat.cand_last ? ST_FIN_START : ST_CAND_RD;
				end
			end
			ST_FIN_START: begin cmd.fin_start = 1'b1; st_d = ST_FIN_B; end
			// rescan both books at the final price; skip an empty side
			ST_FIN_B: begin
				if (stat.buy_empty) st_d = ST_FIN_S;
				else begin
					cmd.scan_b = 1'b1;
					if (stat.scan_last_b) st_d = ST_FIN_S;
				end
			end
			ST_FIN_S: begin
				if (stat.sell_empty) st_d = ST_DONE;
				else begin
					cmd.scan_s = 1'b1;
					if (stat.scan_last_s) st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!stat.acc_pending) begin cmd.done = 1'b1; st_d = ST_OUT; end
			end
			ST_OUT: begin
				out_vld = 1'b1;
				if (out_fire) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end
endmodule

// ----- src/call_auction_clearing_price.sv -----
// Top level of the call-auction clearing block.
// Depends on cacp_pkg, cacp_ctrl, cacp_datapath, cacp_ram.
//
// channel | dir | fields
// s_axis  | in  | tdata {order_qty, order_price, action}
// m_axis  | out | tdata {total_supply, total_demand, matched_qty, clear_price, accepted}
// cfg     | in  | start_price
//
// Order loads step through accept, decode and present with the sink ready.
// Clearing with N = B+S orders walks every candidate over both books, then
// rescans both books at the winner, paced by one book read port each. A one-sided
// book skips the search and goes straight to the rescan at the fallback price.
// Reset empties the books and loads last price 20.0; a stalled output holds
// the result and input is not taken until it is delivered.
`timescale 1ns / 1ps
module call_auction_clearing_price import cacp_pkg::*; #(
	parameter int BOOK_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // action[1:0], order_price[25:2], order_qty[41:26]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [103:0] m_axis_tdata, // accepted, clear_price, matched_qty, demand, supply
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);
	cmd_t  cmd;
	stat_t stat;
	logic [96:0] res;

	assign cfg_ready = 1'b1;

	cacp_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_axis_tvalid && s_axis_tready),
		.out_fire(m_axis_tvalid && m_axis_tready),
		.cfg_fire(cfg_valid && cfg_ready),
		.stat, .cmd, .in_rdy(s_axis_tready), .out_vld(m_axis_tvalid));

	cacp_datapath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .stat, .item(s_axis_tdata[41:0]),
		.cfg_data, .result(res));

	assign m_axis_tdata = {7'd0, res};

	// the result holds while the sink stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	// never take input while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken with pending result");
endmodule
